>>> design/ethernet_mac_register_block_top_defines.svh
`ifndef ETHERNET_MAC_REGISTER_BLOCK_TOP_DEFINES_SVH
`define ETHERNET_MAC_REGISTER_BLOCK_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define EMRB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("emrb assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define EMRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("emrb assertion failed");

`endif

>>> design/emrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package emrb_pkg;

	localparam int DESC_WORDS = 256;
	localparam int DESC_AW    = $clog2(DESC_WORDS);
	localparam int NUM_REGS   = 21;
	localparam int NUM_PLAIN  = 15;

	localparam logic       KIND_READ  = 1'b0;
	localparam logic       KIND_WRITE = 1'b1;
	localparam logic [1:0] ACC_WORD   = 2'd2;

	typedef enum logic [4:0] {
		REG_MODER      = 5'd0,
		REG_INT_SOURCE = 5'd1,
		REG_INT_MASK   = 5'd2,
		REG_IPGT       = 5'd3,
		REG_IPGR1      = 5'd4,
		REG_IPGR2      = 5'd5,
		REG_PACKETLEN  = 5'd6,
		REG_COLLCONF   = 5'd7,
		REG_TX_BD_NUM  = 5'd8,
		REG_CTRLMODER  = 5'd9,
		REG_MIIMODER   = 5'd10,
		REG_MIICOMMAND = 5'd11,
		REG_MIIADDRESS = 5'd12,
		REG_MIITX_DATA = 5'd13,
		REG_MIIRX_DATA = 5'd14,
		REG_MIISTATUS  = 5'd15,
		REG_MAC_ADDR0  = 5'd16,
		REG_MAC_ADDR1  = 5'd17,
		REG_HASH0      = 5'd18,
		REG_HASH1      = 5'd19,
		REG_TXCTRL     = 5'd20
	} reg_idx_t;

	localparam logic [31:0] MODER_RST     = 32'h0000_a000;
	localparam logic [31:0] PACKETLEN_RST = 32'h0040_0600;
	localparam logic [31:0] TX_BD_NUM_RST = 32'h0000_0040;
	localparam logic [31:0] MIIRX_FIRST   = 32'h0000_0022;
	localparam logic [31:0] MIIRX_SECOND  = 32'h0000_1613;
	localparam logic [31:0] MIIRX_LAST    = 32'h0000_ffff;

	localparam int          MODER_TXEN_BIT = 1;
	localparam int          MODER_PAD_BIT  = 15;
	localparam int          BD_READY_BIT   = 15;
	localparam int          BD_PAD_BIT     = 12;
	localparam logic [31:0] BD_CLEAR_MASK  = 32'h0000_81ff;

	localparam logic [3:0] SLOT_NONE = 4'hf;

	// register number to slot in the generic register bank
	localparam logic [3:0] SLOT_OF_REG [NUM_REGS] = '{
		SLOT_NONE, SLOT_NONE, SLOT_NONE, 4'd0, 4'd1, 4'd2, SLOT_NONE, 4'd3, SLOT_NONE,
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8, SLOT_NONE, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
	};

	localparam logic [31:0] PLAIN_RST [NUM_PLAIN] = '{
		32'h12, 32'hc, 32'h12, 32'hf003f, 32'h0, 32'h64, 32'h0, 32'h0,
		32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
	};

	// descriptor memory request decoded from one access
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic               tx;
		logic               ptr_ok;
		logic [DESC_AW-1:0] waddr;
		logic [DESC_AW-1:0] raddr;
		logic [31:0]        wdata;
		logic [6:0]         bdn;
		logic [15:0]        len;
	} bd_req_t;

endpackage

`default_nettype wire

>>> design/emrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module emrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/emrb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module emrb_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc_en,
	input  logic             kind,
	input  logic [1:0]       access_width,
	input  logic [10:0]      byte_offset,
	input  logic [31:0]      write_data,
	output logic [31:0]      rdata,
	output logic             irq,
	output emrb_pkg::bd_req_t bd
);

	logic [31:0] mode_q;
	logic [31:0] src_q;
	logic [31:0] mask_q;
	logic [31:0] packlen_q;
	logic [31:0] bdnum_q;
	logic [31:0] miirx_q;
	logic [31:0] plain_q [emrb_pkg::NUM_PLAIN];

	logic                 word;
	logic                 reg_hit;
	emrb_pkg::reg_idx_t   ridx;
	logic [3:0]           slot;
	logic                 bd_in;
	logic                 ptr_ok;
	logic [7:0]           ptr_idx;
	logic [15:0]          len_raw;
	logic [15:0]          len_min;
	logic                 pad;

	always_comb begin
		word    = access_width == emrb_pkg::ACC_WORD;
		reg_hit = word && !byte_offset[10] && byte_offset[1:0] == 2'b00
			&& byte_offset[9:2] < 8'(emrb_pkg::NUM_REGS);
		ridx    = emrb_pkg::reg_idx_t'(byte_offset[6:2]);
		slot    = reg_hit ? emrb_pkg::SLOT_OF_REG[byte_offset[6:2]] : emrb_pkg::SLOT_NONE;
	end

	always_comb begin
		rdata = '0;
		if (reg_hit && kind == emrb_pkg::KIND_READ) begin
			unique case (ridx)
				emrb_pkg::REG_MODER:      rdata = mode_q;
				emrb_pkg::REG_INT_SOURCE: rdata = src_q;
				emrb_pkg::REG_INT_MASK:   rdata = mask_q;
				emrb_pkg::REG_PACKETLEN:  rdata = packlen_q;
				emrb_pkg::REG_TX_BD_NUM:  rdata = bdnum_q;
				emrb_pkg::REG_MIIRX_DATA: rdata = miirx_q;
				default: begin
					if (slot != emrb_pkg::SLOT_NONE) begin
						rdata = plain_q[slot];
					end
				end
			endcase
		end
	end

	// descriptor area decode, transmit check on the status word
	always_comb begin
		bd_in   = {1'b0, byte_offset[9:2]} < 9'(emrb_pkg::DESC_WORDS);
		ptr_idx = {byte_offset[9:3], 1'b1};
		ptr_ok  = {1'b0, ptr_idx} < 9'(emrb_pkg::DESC_WORDS);
		len_raw = write_data[31:16];
		len_min = packlen_q[31:16];
		pad     = (write_data[emrb_pkg::BD_PAD_BIT] || mode_q[emrb_pkg::MODER_PAD_BIT])
			&& len_min > len_raw;

		bd.rd     = acc_en && word && byte_offset[10] && bd_in && kind == emrb_pkg::KIND_READ;
		bd.wr     = acc_en && word && byte_offset[10] && bd_in && kind == emrb_pkg::KIND_WRITE;
		bd.tx     = bd.wr && byte_offset[2:0] == 3'b000
			&& write_data[emrb_pkg::BD_READY_BIT]
			&& {25'b0, byte_offset[9:3]} < bdnum_q
			&& mode_q[emrb_pkg::MODER_TXEN_BIT];
		bd.ptr_ok = ptr_ok;
		bd.waddr  = byte_offset[emrb_pkg::DESC_AW+1:2];
		// a read fetches its own word, anything else fetches the pointer word
		bd.raddr  = (kind == emrb_pkg::KIND_READ) ? byte_offset[emrb_pkg::DESC_AW+1:2]
			: ptr_idx[emrb_pkg::DESC_AW-1:0];
		bd.wdata  = bd.tx ? (write_data & ~emrb_pkg::BD_CLEAR_MASK) : write_data;
		bd.bdn    = byte_offset[9:3];
		bd.len    = pad ? len_min : len_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= emrb_pkg::MODER_RST;
			src_q     <= '0;
			mask_q    <= '0;
			packlen_q <= emrb_pkg::PACKETLEN_RST;
			bdnum_q   <= emrb_pkg::TX_BD_NUM_RST;
			miirx_q   <= emrb_pkg::MIIRX_FIRST;
			for (int i = 0; i < emrb_pkg::NUM_PLAIN; i++) begin
				plain_q[i] <= emrb_pkg::PLAIN_RST[i];
			end
		end else if (acc_en) begin
			if (bd.tx) begin
				src_q[0] <= 1'b1;
			end
			if (reg_hit && kind == emrb_pkg::KIND_WRITE) begin
				unique case (ridx)
					emrb_pkg::REG_MODER:      mode_q    <= write_data;
					emrb_pkg::REG_INT_SOURCE: src_q     <= src_q & ~write_data;
					emrb_pkg::REG_INT_MASK:   mask_q    <= write_data;
					emrb_pkg::REG_PACKETLEN:  packlen_q <= write_data;
					emrb_pkg::REG_TX_BD_NUM:  bdnum_q   <= write_data;
					emrb_pkg::REG_MIIRX_DATA: miirx_q   <= write_data;
					default: begin
						if (slot != emrb_pkg::SLOT_NONE) begin
							plain_q[slot] <= write_data;
						end
					end
				endcase
			end else if (reg_hit && ridx == emrb_pkg::REG_MIIRX_DATA) begin
				// each read advances the canned phy answer until it holds the last value
				if (miirx_q == emrb_pkg::MIIRX_SECOND) begin
					miirx_q <= emrb_pkg::MIIRX_LAST;
				end else if (miirx_q == emrb_pkg::MIIRX_FIRST) begin
					miirx_q <= emrb_pkg::MIIRX_SECOND;
				end
			end
		end
	end

	assign irq = |(mask_q & src_q);

endmodule

`default_nettype wire

>>> design/ethernet_mac_register_block_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Register file and buffer-descriptor memory of an ethmac-style MAC. An access is
// taken when start is high and busy is low; its result shows on the result ports
// for exactly one cycle, marked by done, after passing the s1 and result registers.
// The receiver cannot stall: a result not captured in that cycle is gone. The
// descriptor RAM read is registered (an access reads its descriptor word or, for a
// transmit, the pointer word). A new access is refused while one is in the s1
// registers. After reset the descriptor RAM is swept to zero, one word a cycle,
// and busy stays high until all DESC_WORDS (256) words are clear.
module ethernet_mac_register_block_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [1:0]  access_width,
	input  logic [10:0] byte_offset,
	input  logic [31:0] write_data,
	output logic        done,
	output logic [31:0] read_data,
	output logic        irq_line,
	output logic        tx_start,
	output logic [6:0]  tx_descriptor,
	output logic [15:0] tx_length,
	output logic [31:0] tx_pointer
);

	logic                          acc_en;
	logic [31:0]                   reg_rdata;
	logic                          irq;
	emrb_pkg::bd_req_t             bd;

	logic                          clearing_q;
	logic [emrb_pkg::DESC_AW-1:0]  clr_cnt_q;

	logic                          ram_we;
	logic [emrb_pkg::DESC_AW-1:0]  ram_waddr;
	logic [31:0]                   ram_wdata;
	logic [31:0]                   ram_rdata;

	logic                          valid_s1;
	logic                          bd_rd_s1;
	logic [31:0]                   rdata_s1;
	logic                          tx_s1;
	logic                          ptr_ok_s1;
	logic [6:0]                    bdn_s1;
	logic [15:0]                   len_s1;

	logic                          done_q;
	logic [31:0]                   read_data_q;
	logic                          irq_q;
	logic                          tx_start_q;
	logic [6:0]                    tx_descriptor_q;
	logic [15:0]                   tx_length_q;
	logic [31:0]                   tx_pointer_q;

	assign busy   = clearing_q | valid_s1;
	assign acc_en = start & ~busy;

	emrb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc_en       (acc_en),
		.kind         (kind),
		.access_width (access_width),
		.byte_offset  (byte_offset),
		.write_data   (write_data),
		.rdata        (reg_rdata),
		.irq          (irq),
		.bd           (bd)
	);

	// zero sweep of the descriptor RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == emrb_pkg::DESC_AW'(emrb_pkg::DESC_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ram_we    = clearing_q | bd.wr;
		ram_waddr = clearing_q ? clr_cnt_q : bd.waddr;
		ram_wdata = clearing_q ? '0 : bd.wdata;
	end

	emrb_ram #(
		.WIDTH (32),
		.DEPTH (emrb_pkg::DESC_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (bd.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc_en;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			bd_rd_s1  <= bd.rd;
			rdata_s1  <= reg_rdata;
			tx_s1     <= bd.tx;
			ptr_ok_s1 <= bd.ptr_ok;
			bdn_s1    <= bd.bdn;
			len_s1    <= bd.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q     <= bd_rd_s1 ? ram_rdata : rdata_s1;
			irq_q           <= irq;
			tx_start_q      <= tx_s1;
			tx_descriptor_q <= tx_s1 ? bdn_s1 : '0;
			tx_length_q     <= tx_s1 ? len_s1 : '0;
			tx_pointer_q    <= (tx_s1 && ptr_ok_s1) ? ram_rdata : '0;
		end
	end

	assign done          = done_q;
	assign read_data     = read_data_q;
	assign irq_line      = irq_q;
	assign tx_start      = done_q & tx_start_q;
	assign tx_descriptor = tx_descriptor_q;
	assign tx_length     = tx_length_q;
	assign tx_pointer    = tx_pointer_q;

endmodule

`default_nettype wire

>>> design/emrb_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ethernet_mac_register_block_top_defines.svh"

module emrb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        tx_start,
	input logic [6:0]  tx_descriptor,
	input logic [15:0] tx_length,
	input logic [31:0] tx_pointer
);

	// every taken transfer is followed by its result on done
	`EMRB_ASSERT_NEXT(a_result_follows, start && !busy, ##1 done)

	// no result without a taken transfer before it
	`EMRB_ASSERT_SAME(a_no_stray_result, done, $past(start && !busy, 2))

	`EMRB_ASSERT_SAME(a_tx_in_result, tx_start, done)

	// transmit fields are zero unless a transmit is reported
	`EMRB_ASSERT_SAME(a_tx_fields_quiet, done && !tx_start,
		tx_descriptor == 7'd0 && tx_length == 16'd0 && tx_pointer == 32'd0)

endmodule

bind ethernet_mac_register_block_top emrb_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.tx_start      (tx_start),
	.tx_descriptor (tx_descriptor),
	.tx_length     (tx_length),
	.tx_pointer    (tx_pointer)
);

`default_nettype wire

>>> test/emrb_reply_checker.sv
`timescale 1ns / 1ps

module emrb_reply_checker
	import emrb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        kind,
	input  logic [1:0]  access_width,
	input  logic [10:0] byte_offset,
	input  logic [31:0] write_data,
	input  logic        done,
	input  logic [31:0] read_data,
	input  logic        irq_line,
	input  logic        tx_start,
	input  logic [6:0]  tx_descriptor,
	input  logic [15:0] tx_length,
	input  logic [31:0] tx_pointer,
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_line;
		logic        tx_start;
		logic [6:0]  tx_descriptor;
		logic [15:0] tx_length;
		logic [31:0] tx_pointer;
	} bus_reply_t;

	logic [31:0] mac_regs [NUM_REGS];
	logic [31:0] desc_words [DESC_WORDS];
	bus_reply_t  pending_replies [$];
	bus_reply_t  oldest_reply;

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	task automatic reset_mac_state();
		for (int i = 0; i < NUM_REGS; i++) begin
			mac_regs[i] = '0;
		end
		for (int i = 0; i < DESC_WORDS; i++) begin
			desc_words[i] = '0;
		end
		mac_regs[REG_MODER]      = MODER_RST;
		mac_regs[REG_IPGT]       = 32'h12;
		mac_regs[REG_IPGR1]      = 32'hc;
		mac_regs[REG_IPGR2]      = 32'h12;
		mac_regs[REG_PACKETLEN]  = PACKETLEN_RST;
		mac_regs[REG_COLLCONF]   = 32'hf003f;
		mac_regs[REG_TX_BD_NUM]  = TX_BD_NUM_RST;
		mac_regs[REG_MIIMODER]   = 32'h64;
		mac_regs[REG_MIIRX_DATA] = MIIRX_FIRST;
	endtask

	// applies one bus access to the mirrored state and returns what the block should report
	function automatic bus_reply_t perform_access(logic acc_kind, logic [1:0] acc_width,
			logic [10:0] ofs, logic [31:0] data);
		bus_reply_t  reply;
		logic [7:0]  widx;
		logic [6:0]  bdn;
		logic [31:0] status;
		logic [15:0] len;
		logic [15:0] min_len;
		reg_idx_t    ri;
		reply = '0;
		if (acc_width == ACC_WORD) begin
			if (ofs[10]) begin
				widx = ofs[9:2];
				bdn  = ofs[9:3];
				if (acc_kind == KIND_READ) begin
					reply.read_data = desc_words[widx];
				end else begin
					desc_words[widx] = data;
					if (ofs[2:0] == 3'b000 && data[BD_READY_BIT]
							&& {25'd0, bdn} < mac_regs[REG_TX_BD_NUM]
							&& mac_regs[REG_MODER][MODER_TXEN_BIT]) begin
						status  = desc_words[{bdn, 1'b0}];
						len     = status[31:16];
						min_len = mac_regs[REG_PACKETLEN][31:16];
						if ((status[BD_PAD_BIT] || mac_regs[REG_MODER][MODER_PAD_BIT])
								&& min_len > len) begin
							len = min_len;
						end
						reply.tx_pointer    = desc_words[{bdn, 1'b1}];
						desc_words[{bdn, 1'b0}] = status & ~BD_CLEAR_MASK;
						mac_regs[REG_INT_SOURCE][0] = 1'b1;
						reply.tx_start      = 1'b1;
						reply.tx_descriptor = bdn;
						reply.tx_length     = len;
					end
				end
			end else if (ofs[1:0] == 2'b00 && ofs[9:2] < NUM_REGS) begin
				ri = reg_idx_t'(ofs[6:2]);
				if (acc_kind == KIND_READ) begin
					reply.read_data = mac_regs[ri];
					// mii receive data walks a fixed sequence on each read
					if (ri == REG_MIIRX_DATA) begin
						if (mac_regs[ri] == MIIRX_SECOND) begin
							mac_regs[ri] = MIIRX_LAST;
						end else if (mac_regs[ri] == MIIRX_FIRST) begin
							mac_regs[ri] = MIIRX_SECOND;
						end
					end
				end else if (ri == REG_INT_SOURCE) begin
					mac_regs[ri] = mac_regs[ri] & ~data;
				end else begin
					mac_regs[ri] = data;
				end
			end
		end
		reply.irq_line = |(mac_regs[REG_INT_MASK] & mac_regs[REG_INT_SOURCE]);
		return reply;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_mac_state();
			pending_replies.delete();
		end else begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$error("result transfer with no access outstanding");
					fail_count++;
				end else begin
					oldest_reply = pending_replies.pop_front();
					check_field("read_data", oldest_reply.read_data, read_data);
					check_field("irq_line", oldest_reply.irq_line, irq_line);
					check_field("tx_start", oldest_reply.tx_start, tx_start);
					check_field("tx_descriptor", oldest_reply.tx_descriptor, tx_descriptor);
					check_field("tx_length", oldest_reply.tx_length, tx_length);
					check_field("tx_pointer", oldest_reply.tx_pointer, tx_pointer);
				end
			end
			if (start && !busy) begin
				pending_replies.push_back(perform_access(kind, access_width, byte_offset,
					write_data));
			end
		end
		outstanding = pending_replies.size();
	end

endmodule

>>> test/ethernet_mac_register_block_top_test.sv
`timescale 1ns / 1ps

module ethernet_mac_register_block_top_test;
	import emrb_pkg::*;

	localparam logic [1:0] ACC_BYTE  = 2'd0;
	localparam logic [1:0] ACC_HALF  = 2'd1;
	localparam logic [1:0] ACC_RSVD  = 2'd3;
	localparam int         TOTAL_ITEMS = 1475;
	localparam int         DRAIN_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        kind = 1'b0;
	logic [1:0]  access_width = '0;
	logic [10:0] byte_offset = '0;
	logic [31:0] write_data = '0;
	logic        done;
	logic [31:0] read_data;
	logic        irq_line;
	logic        tx_start;
	logic [6:0]  tx_descriptor;
	logic [15:0] tx_length;
	logic [31:0] tx_pointer;
	int          fail_count;
	int          outstanding;

	int issued = 0;
	int burst_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ethernet_mac_register_block_top u_dut (.*);

	emrb_reply_checker u_checker (.*);

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [10:0] reg_ofs(reg_idx_t r);
		return {4'b0, r, 2'b00};
	endfunction

	function automatic logic [10:0] desc_ofs(logic [6:0] bdn, logic ptr_word);
		return 11'h400 | {1'b0, bdn, ptr_word, 2'b00};
	endfunction

	// holds one access on the bus until it is taken, then maybe idles
	task automatic issue_access(input logic k, input logic [1:0] w, input logic [10:0] ofs,
			input logic [31:0] d);
		int pick;
		int gap;
		start        <= 1'b1;
		kind         <= k;
		access_width <= w;
		byte_offset  <= ofs;
		write_data   <= d;
		do @(posedge clk); while (busy);
		issued++;
		gap = 0;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				burst_left = $urandom_range(20, 60);
			end else if (pick < 55) begin
				gap = 0;
			end else if (pick < 90) begin
				gap = $urandom_range(1, 3);
			end else begin
				gap = $urandom_range(8, 40);
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_replies();
		int waited;
		waited = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			waited++;
		end while (outstanding != 0 && waited < DRAIN_LIMIT);
		@(posedge clk);
	endtask

	initial begin
		logic [6:0]  bdn;
		logic [31:0] data;
		reg_idx_t    ri;
		int          pick;
		bit          paused_once;
		paused_once = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, narrow and unmapped accesses
		issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_MODER), 32'h0);
		issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_TX_BD_NUM), 32'hffff_ffff);
		issue_access(KIND_READ, ACC_BYTE, reg_ofs(REG_MODER), 32'h0);
		issue_access(KIND_WRITE, ACC_HALF, reg_ofs(REG_IPGT), 32'hffff_ffff);
		issue_access(KIND_WRITE, ACC_RSVD, reg_ofs(REG_IPGT), 32'hffff_ffff);
		issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_IPGT), 32'h0);
		issue_access(KIND_READ, ACC_WORD, 11'h054, 32'h0);
		issue_access(KIND_READ, ACC_WORD, 11'h006, 32'h0);
		issue_access(KIND_READ, ACC_WORD, 11'h7ff, 32'h0);
		// mii receive data sequence, then a write that must not touch mii status
		repeat (4) issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_MIIRX_DATA), 32'h0);
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_MIIRX_DATA), MIIRX_SECOND);
		issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_MIISTATUS), 32'h0);
		issue_access(KIND_READ, ACC_WORD, reg_ofs(REG_MIIRX_DATA), 32'h0);
		// ready write while transmit is off, then with it on and padding
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd1, 1'b1), 32'hffff_ffff);
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd1, 1'b0), 32'h0010_9000);
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_INT_MASK), 32'hffff_ffff);
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_MODER), 32'h0000_a002);
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd1, 1'b0), 32'h0010_9000);
		issue_access(KIND_READ, ACC_WORD, desc_ofs(7'd1, 1'b0), 32'h0);
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_INT_SOURCE), 32'hffff_ffff);
		// unaligned status write and descriptor past the count never transmit
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd1, 1'b0) | 11'd1, 32'h0000_8000);
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_TX_BD_NUM), 32'h0);
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd0, 1'b0), 32'h0000_8000);
		// last descriptor, all ones
		issue_access(KIND_WRITE, ACC_WORD, reg_ofs(REG_TX_BD_NUM), 32'hffff_ffff);
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd127, 1'b1), 32'h0);
		issue_access(KIND_WRITE, ACC_WORD, desc_ofs(7'd127, 1'b0), 32'hffff_ffff);
		drain_replies();

		while (issued < TOTAL_ITEMS) begin
			if (!paused_once && issued >= TOTAL_ITEMS / 2) begin
				drain_replies();
				paused_once = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// pointer then status, most often with ready set
				bdn = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 7))
					: 7'($urandom_range(0, 127));
				issue_access(KIND_WRITE, ACC_WORD, desc_ofs(bdn, 1'b1), $urandom);
				data = $urandom;
				if ($urandom_range(0, 9) != 0) data[BD_READY_BIT] = 1'b1;
				if ($urandom_range(0, 9) < 7) data[31:16] = 16'($urandom_range(0, 120));
				issue_access(KIND_WRITE, ACC_WORD, desc_ofs(bdn, 1'b0), data);
				if ($urandom_range(0, 1) == 1) begin
					issue_access(KIND_READ, ACC_WORD, desc_ofs(bdn, 1'b0), $urandom);
				end
			end else if (pick < 50) begin
				issue_access(KIND_READ, ACC_WORD, 11'h400 | 11'($urandom_range(0, 1023)),
					$urandom);
			end else if (pick < 65) begin
				ri = reg_idx_t'($urandom_range(0, NUM_REGS - 1));
				issue_access(KIND_READ, ACC_WORD, reg_ofs(ri), $urandom);
			end else if (pick < 85) begin
				ri = reg_idx_t'($urandom_range(0, NUM_REGS - 1));
				data = $urandom;
				case (ri)
					REG_MODER: begin
						if ($urandom_range(0, 9) < 8) data[MODER_TXEN_BIT] = 1'b1;
					end
					REG_PACKETLEN: begin
						if ($urandom_range(0, 9) < 8) data[31:16] = 16'($urandom_range(0, 200));
					end
					REG_TX_BD_NUM: begin
						if ($urandom_range(0, 9) < 8) data = $urandom_range(0, 130);
					end
					REG_MIIRX_DATA: begin
						pick = $urandom_range(0, 2);
						if (pick == 0) data = MIIRX_FIRST;
						else if (pick == 1) data = MIIRX_SECOND;
					end
					default: begin
					end
				endcase
				issue_access(KIND_WRITE, ACC_WORD, reg_ofs(ri), data);
			end else begin
				issue_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
					11'($urandom_range(0, 2047)), $urandom);
			end
		end

		drain_replies();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
